// ===== design/bis_pkg.sv =====
// shared constants and types for the bilinear image sampler
package bis_pkg;

    // image store geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 8;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // field widths
    localparam int CFG_W   = 10;
    localparam int COORD_W = 18;
    localparam int IX_W    = COORD_W - FRAC_BITS;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int OUT_W   = 16;
    localparam int OUT_FRAC = 8;

    // stream packing
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;
    localparam int S_USER_W = 2;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(512);

    // blend arithmetic
    localparam int WGT_W = 2 * FRAC_BITS + 1;
    localparam int ACC_W = CH_W + 2 * FRAC_BITS;
    localparam int RND_D = (2 * FRAC_BITS > OUT_FRAC) ? (2 * FRAC_BITS - OUT_FRAC) : 0;
    localparam int LSH_D = (2 * FRAC_BITS > OUT_FRAC) ? 0 : (OUT_FRAC - 2 * FRAC_BITS);
    localparam int RND_HALF = (RND_D > 0) ? (1 << (RND_D - 1)) : 0;
    localparam logic [FRAC_BITS:0] FIX_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

    // request codes
    typedef enum logic [S_USER_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_SAMPLE = 2'd2
    } req_t;

    // register indexes
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

endpackage

// ===== design/bis_ram.sv =====
// generic single-port ram with registered read
module bis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, write or read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bilinear_image_sampler.sv =====
// top level: rgb pixel store with pixel write, pixel read and bilinear sample
//
//  channel   | direction | transaction content
//  ----------+-----------+---------------------------------------------------
//  s_        | in        | one request: write, read or bilinear sample
//  m_        | out       | one result per read or sample, none for a write
//  apb       | in/out    | image_width at 0x0, image_height at 0x4
//
// a write ends after the exec step; a read or sample also passes the drain and final steps:
// a sample makes four reads through the single port of the pixel ram, one per cycle, then
// folds in the last pixel in the drain step and loads the output register in the final step.
// a read or sample outside the image skips the drain step; an unknown request code gives no result.
// a stalled m_ side holds the block in its final step; one new request is
// still taken in that step once the output register frees up.
// reset is synchronous; the pixel ram has no reset and holds garbage until written.
module bilinear_image_sampler
    import bis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // x_coord[17:0], y_coord[35:18], write_red[43:36], write_green[51:44],
    // write_blue[59:52], zero fill[63:60]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [S_USER_W-1:0]   s_tuser,

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32]
    output logic [M_DATA_W-1:0]   m_tdata,
    // out_valid[0]
    output logic                  m_tuser,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration registers
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             apb_wr;
    reg_idx_t         apb_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite & pready;
    assign apb_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (apb_wr) begin
            unique case (apb_idx)
                REG_IMAGE_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (apb_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // effective image size, capped at the store size
    logic [CFG_W-1:0] weff, heff;
    assign weff = (32'(width_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign heff = (32'(height_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_reg;

    // request field unpacking
    localparam int CMP_W = COORD_W + CFG_W + FRAC_BITS;

    logic [COORD_W-1:0] in_x, in_y;
    logic [PIX_W-1:0]   in_pix;
    logic [IX_W-1:0]    in_ix, in_iy;
    logic               in_neg, in_rng, in_smp;
    logic [CMP_W-1:0]   lim_x, lim_y;

    assign in_x   = s_tdata[COORD_W-1:0];
    assign in_y   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pix = {s_tdata[2*COORD_W+CH_W-1:2*COORD_W],
                     s_tdata[2*COORD_W+2*CH_W-1:2*COORD_W+CH_W],
                     s_tdata[2*COORD_W+3*CH_W-1:2*COORD_W+2*CH_W]};
    assign in_ix  = in_x[COORD_W-1:FRAC_BITS];
    assign in_iy  = in_y[COORD_W-1:FRAC_BITS];
    assign in_neg = in_x[COORD_W-1] | in_y[COORD_W-1];

    // range checks for pixel access and for the 2x2 sample window
    assign lim_x  = CMP_W'(weff - CFG_W'(1)) << FRAC_BITS;
    assign lim_y  = CMP_W'(heff - CFG_W'(1)) << FRAC_BITS;
    assign in_rng = !in_neg && (CMP_W'(in_ix) < CMP_W'(weff))
                            && (CMP_W'(in_iy) < CMP_W'(heff));
    assign in_smp = !in_neg && (weff != '0) && (heff != '0)
                            && (CMP_W'(in_x) < lim_x) && (CMP_W'(in_y) < lim_y);

    // sequencer state
    state_t                state_reg, state_next;
    logic [1:0]            step_reg, step_next;
    logic                  pend_reg, pend_next;
    logic                  s_fire, out_free, out_load;

    // captured request
    logic [S_USER_W-1:0]   req_reg;
    logic                  rng_reg, smp_reg;
    logic [COL_W-1:0]      ix_reg;
    logic [ROW_W-1:0]      iy_reg;
    logic [FRAC_BITS-1:0]  fx_reg, fy_reg;
    logic [PIX_W-1:0]      wpix_reg;

    // blend datapath
    logic [WGT_W-1:0]      wgt_reg, wgt_next;
    logic [ACC_W-1:0]      acc_reg  [3];
    logic [ACC_W-1:0]      acc_next [3];
    logic [ACC_W:0]        acc_rnd  [3];
    logic [OUT_W-1:0]      scaled   [3];

    // output register
    logic                  m_tvalid_reg;
    logic                  m_flag_reg;
    logic [M_DATA_W-1:0]   m_data_reg;

    // pixel ram port
    logic                  ram_en, ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [PIX_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      row_sel;
    logic [COL_W-1:0]      col_sel;
    logic [FRAC_BITS:0]    wx_sel, wy_sel;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && out_free;

    // neighbour address for the current step: bit 0 picks the column, bit 1 the row
    assign row_sel  = iy_reg + ROW_W'(step_reg[1]);
    assign col_sel  = ix_reg + COL_W'(step_reg[0]);
    assign ram_addr = ADDR_W'(row_sel) * ROW_PITCH + ADDR_W'(col_sel);

    // bilinear weight of the current neighbour
    assign wx_sel   = step_reg[0] ? (FRAC_BITS + 1)'(fx_reg) : FIX_ONE - (FRAC_BITS + 1)'(fx_reg);
    assign wy_sel   = step_reg[1] ? (FRAC_BITS + 1)'(fy_reg) : FIX_ONE - (FRAC_BITS + 1)'(fy_reg);
    assign wgt_next = WGT_W'(wx_sel) * WGT_W'(wy_sel);

    // step control; the single port keeps writes and reads of one entry ordered
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                    step_next  = '0;
                end
            end
            ST_EXEC: begin
                case (req_reg)
                    REQ_WRITE: begin
                        ram_en     = rng_reg;
                        ram_we     = rng_reg;
                        state_next = ST_IDLE;
                    end
                    REQ_READ: begin
                        ram_en     = rng_reg;
                        pend_next  = rng_reg;
                        state_next = rng_reg ? ST_DRAIN : ST_FIN;
                    end
                    REQ_SAMPLE: begin
                        ram_en    = smp_reg;
                        pend_next = smp_reg;
                        if (!smp_reg) begin
                            state_next = ST_FIN;
                        end else if (step_reg == 2'd3) begin
                            state_next = ST_DRAIN;
                        end else begin
                            step_next = step_reg + 2'd1;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                    step_next  = '0;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // capture the request; a read uses zero fractions so its weight is one
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg  <= s_tuser;
            rng_reg  <= in_rng;
            smp_reg  <= in_smp;
            ix_reg   <= COL_W'(in_ix);
            iy_reg   <= ROW_W'(in_iy);
            fx_reg   <= (s_tuser == REQ_SAMPLE) ? in_x[FRAC_BITS-1:0] : '0;
            fy_reg   <= (s_tuser == REQ_SAMPLE) ? in_y[FRAC_BITS-1:0] : '0;
            wpix_reg <= in_pix;
        end
    end

    // weighted accumulation as each pixel returns from the ram
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_next[c] = acc_reg[c];
            if (pend_reg) begin
                acc_next[c] = acc_reg[c]
                    + ACC_W'(ram_rdata[PIX_W-1-CH_W*c -: CH_W]) * ACC_W'(wgt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        wgt_reg <= wgt_next;
        for (int c = 0; c < 3; c++) begin
            if (s_fire) begin
                acc_reg[c] <= '0;
            end else begin
                acc_reg[c] <= acc_next[c];
            end
        end
    end

    // round to 8 fraction bits; the sum never exceeds 255 in integer part
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_rnd[c] = ((ACC_W + 1)'(acc_reg[c]) + (ACC_W + 1)'(RND_HALF)) >> RND_D;
            scaled[c]  = OUT_W'(acc_rnd[c] << LSH_D);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_flag_reg <= (req_reg == REQ_SAMPLE) ? smp_reg : rng_reg;
            m_data_reg <= {scaled[2], scaled[1], scaled[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flag_reg;

    // pixel store
    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_pix_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wpix_reg),
        .rdata (ram_rdata)
    );

    // a result only appears after the final step
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside final step");

    // ram writes only for in-range write requests
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC) && (req_reg == REQ_WRITE) && rng_reg)
        else $error("pixel write outside image or out of sequence");

    // returning read data always follows a read issue
    a_pend_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(ram_en && !ram_we))
        else $error("accumulate without a read");

    // no new request while a result is stuck in the output register
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && m_tvalid_reg && !m_tready |-> !s_tready)
        else $error("request taken while result blocked");

endmodule
